// ===== rtl/swsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package swsh_pkg;

    // Square root: 22 bit radicand, 11 bit root, one root bit per cell
    localparam int RAD_W  = 22;
    localparam int ROOT_W = 11;
    localparam int SREM_W = 12;

    // Normal division: 11 bit magnitude times 2^14 over the radius
    localparam int MAG_W  = 11;
    localparam int DREM_W = 11;
    localparam int QUO_W  = 15;

    // CORDIC datapath and angle widths, pi = 65536
    localparam int CRD_W  = 24;
    localparam int ANG_W  = 18;
    localparam int AOUT_W = 17;
    localparam int ATAN_W = 15;

    localparam logic [ATAN_W-1:0] ATAN_TABLE [24] = '{
        15'd16384, 15'd9672, 15'd5110, 15'd2594, 15'd1302, 15'd652, 15'd326, 15'd163,
        15'd81, 15'd41, 15'd20, 15'd10, 15'd5, 15'd3, 15'd1, 15'd1,
        15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0
    };

    typedef enum logic [2:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_RADIUS       = 3'd2,
        CFG_LIGHT_X      = 3'd3,
        CFG_LIGHT_Y      = 3'd4,
        CFG_LIGHT_Z      = 3'd5,
        CFG_FRAME_WIDTH  = 3'd6,
        CFG_FRAME_HEIGHT = 3'd7
    } cfg_index_t;

    typedef enum logic {
        FUNC_STORE  = 1'b0,
        FUNC_RENDER = 1'b1
    } func_t;

endpackage
`default_nettype wire

// ===== rtl/sphere_wrap_shader_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// s_        in         tuser: func; tdata: pos_x, pos_y, in_red, in_green, in_blue
// m_        out        tdata: out_red, out_green, out_blue, out_alpha
// cfg_      in         cfg_we, cfg_index, cfg_wdata (plain register writes)
//
// One transfer is taken every clock unless the pipeline holds; a render item walks
// through 2 + 11 + CORDIC_STEPS + 15 + 3 register stages (47 at the defaults), set
// by the square-root, CORDIC and divider cell chains that every item walks through.
// Store items take the same path and write the source frame at the memory stage,
// so writes and reads stay in item order; store items give no output transfer.
// The whole pipeline holds while a finished result waits on m_tready.
// Reset clears only the valid bits and config registers, not the source frame.
module sphere_wrap_shader_unit
    import swsh_pkg::*;
#(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // pos_x[6:0], pos_y[13:7], in_red[21:14],
                                        // in_green[29:22], in_blue[37:30], zero pad
    input  wire logic        s_tuser,   // func
    // result item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_red[7:0], out_green[15:8],
                                        // out_blue[23:16], out_alpha[31:24]
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SQ_N   = ROOT_W;
    localparam int DV_N   = QUO_W;

    typedef struct packed {
        logic        func;
        logic        in_sphere;
        logic [6:0]  pos_x;
        logic [6:0]  pos_y;
        logic [23:0] rgb;
    } ctx_t;

    typedef struct packed {
        ctx_t               ctx;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
    } sq_side_t;

    typedef struct packed {
        ctx_t               ctx;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic [ROOT_W-1:0]  z;
    } cr_side_t;

    typedef struct packed {
        ctx_t              ctx;
        logic              sx;
        logic              sy;
        logic [AOUT_W-1:0] a;
        logic [AOUT_W-1:0] b;
    } dv_side_t;

    localparam int SQ_SW = $bits(sq_side_t);
    localparam int CR_SW = $bits(cr_side_t);
    localparam int DV_SW = $bits(dv_side_t);

    // ---------------- configuration registers ----------------
    logic [10:0]        center_x_reg, center_y_reg, radius_reg;
    logic signed [15:0] light_x_reg, light_y_reg;
    logic [14:0]        light_z_reg;
    logic [7:0]         frame_width_reg, frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg     <= 11'd1024;
            center_y_reg     <= 11'd1024;
            radius_reg       <= 11'd1024;
            light_x_reg      <= 16'sd0;
            light_y_reg      <= 16'sd0;
            light_z_reg      <= 15'd16384;
            frame_width_reg  <= 8'd128;
            frame_height_reg <= 8'd128;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER_X:     center_x_reg     <= cfg_wdata[10:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_wdata[10:0];
                CFG_RADIUS:       radius_reg       <= cfg_wdata[10:0];
                CFG_LIGHT_X:      light_x_reg      <= cfg_wdata;
                CFG_LIGHT_Y:      light_y_reg      <= cfg_wdata;
                CFG_LIGHT_Z:      light_z_reg      <= cfg_wdata[14:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[7:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output holds an untaken result
    logic m_valid_reg;
    logic en;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 0: offsets from the centre ----------------
    logic               v0_reg;
    ctx_t               ctx0_reg;
    logic signed [12:0] dx0_reg, dy0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx0_reg.func      <= s_tuser;
            ctx0_reg.in_sphere <= 1'b0;
            ctx0_reg.pos_x     <= s_tdata[6:0];
            ctx0_reg.pos_y     <= s_tdata[13:7];
            ctx0_reg.rgb       <= s_tdata[37:14];
            dx0_reg <= $signed({2'b00, s_tdata[6:0], 4'b0000}) - $signed({2'b00, center_x_reg});
            dy0_reg <= $signed({2'b00, s_tdata[13:7], 4'b0000}) - $signed({2'b00, center_y_reg});
        end
    end

    // ---------------- stage 1: squares ----------------
    logic               v1_reg;
    ctx_t               ctx1_reg;
    logic signed [12:0] dx1_reg, dy1_reg;
    logic [RAD_W-1:0]   dx2_reg, dy2_reg, r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx1_reg <= ctx0_reg;
            dx1_reg  <= dx0_reg;
            dy1_reg  <= dy0_reg;
            dx2_reg  <= RAD_W'(26'(dx0_reg) * 26'(dx0_reg));
            dy2_reg  <= RAD_W'(26'(dy0_reg) * 26'(dy0_reg));
            r2_reg   <= RAD_W'(radius_reg) * RAD_W'(radius_reg);
        end
    end

    // In-sphere test and the two radicands, r^2 - d^2 and r^2 - dy^2
    logic [RAD_W:0]   d2;
    logic             in_sphere;
    sq_side_t         sq_in_side;

    assign d2        = (RAD_W+1)'(dx2_reg) + (RAD_W+1)'(dy2_reg);
    assign in_sphere = (d2 < (RAD_W+1)'(r2_reg));

    always_comb begin
        sq_in_side               = '0;
        sq_in_side.ctx           = ctx1_reg;
        sq_in_side.ctx.in_sphere = in_sphere;
        sq_in_side.dx            = dx1_reg;
        sq_in_side.dy            = dy1_reg;
    end

    // ---------------- square-root chain ----------------
    logic                          sq_valid [SQ_N+1];
    logic [SQ_SW-1:0]              sq_side  [SQ_N+1];
    logic [1:0][RAD_W-1:0]         sq_rad   [SQ_N+1];
    logic [1:0][SREM_W-1:0]        sq_rem   [SQ_N+1];
    logic [1:0][ROOT_W-1:0]        sq_root  [SQ_N+1];

    assign sq_valid[0]   = v1_reg;
    assign sq_side[0]    = sq_in_side;
    assign sq_rad[0][0]  = in_sphere ? RAD_W'((RAD_W+1)'(r2_reg) - d2) : '0;
    assign sq_rad[0][1]  = in_sphere ? (r2_reg - dy2_reg) : '0;
    assign sq_rem[0]     = '0;
    assign sq_root[0]    = '0;

    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        swsh_sqrt_cell #(
            .LANES  (2),
            .SIDE_W (SQ_SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid[g]),
            .in_side   (sq_side[g]),
            .in_rad    (sq_rad[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .out_valid (sq_valid[g+1]),
            .out_side  (sq_side[g+1]),
            .out_rad   (sq_rad[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1])
        );
    end

    // ---------------- CORDIC chain: a = atan2(dx, z), b = atan2(dy, q) ----------------
    sq_side_t sq_out;
    cr_side_t cr_in_side;

    assign sq_out = sq_side[SQ_N];

    always_comb begin
        cr_in_side     = '0;
        cr_in_side.ctx = sq_out.ctx;
        cr_in_side.dx  = sq_out.dx;
        cr_in_side.dy  = sq_out.dy;
        cr_in_side.z   = sq_root[SQ_N][0];
    end

    logic                       cr_valid [CORDIC_STEPS+1];
    logic [CR_SW-1:0]           cr_side  [CORDIC_STEPS+1];
    logic [1:0][CRD_W-1:0]      cr_x     [CORDIC_STEPS+1];
    logic [1:0][CRD_W-1:0]      cr_y     [CORDIC_STEPS+1];
    logic [1:0][ANG_W-1:0]      cr_ang   [CORDIC_STEPS+1];

    assign cr_valid[0]  = sq_valid[SQ_N];
    assign cr_side[0]   = cr_in_side;
    assign cr_x[0][0]   = CRD_W'({sq_root[SQ_N][0], 8'h00});
    assign cr_x[0][1]   = CRD_W'({sq_root[SQ_N][1], 8'h00});
    assign cr_y[0][0]   = CRD_W'($signed({sq_out.dx, 8'h00}));
    assign cr_y[0][1]   = CRD_W'($signed({sq_out.dy, 8'h00}));
    assign cr_ang[0]    = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        swsh_cordic_cell #(
            .LANES  (2),
            .SIDE_W (CR_SW),
            .STEP   (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cr_valid[g]),
            .in_side   (cr_side[g]),
            .in_x      (cr_x[g]),
            .in_y      (cr_y[g]),
            .in_ang    (cr_ang[g]),
            .out_valid (cr_valid[g+1]),
            .out_side  (cr_side[g+1]),
            .out_x     (cr_x[g+1]),
            .out_y     (cr_y[g+1]),
            .out_ang   (cr_ang[g+1])
        );
    end

    // Clamp the angles to -pi/2..pi/2
    function automatic logic [AOUT_W-1:0] clamp_angle(input logic [ANG_W-1:0] ang);
        logic signed [ANG_W-1:0] s;
        s = $signed(ang);
        if (s > $signed(ANG_W'(32768))) begin
            return AOUT_W'(32768);
        end else if (s < -$signed(ANG_W'(32768))) begin
            return AOUT_W'(-32768);
        end
        return AOUT_W'(s);
    endfunction

    // ---------------- divider chain: normals n = |v| * 2^14 / r ----------------
    cr_side_t           cr_out;
    dv_side_t           dv_in_side;
    logic [12:0]        dx_mag, dy_mag;
    logic [2:0][MAG_W-1:0] mag;

    assign cr_out = cr_side[CORDIC_STEPS];
    assign dx_mag = cr_out.dx[12] ? 13'(-cr_out.dx) : 13'(cr_out.dx);
    assign dy_mag = cr_out.dy[12] ? 13'(-cr_out.dy) : 13'(cr_out.dy);
    assign mag[0] = MAG_W'(dx_mag);
    assign mag[1] = MAG_W'(dy_mag);
    assign mag[2] = cr_out.z;

    always_comb begin
        dv_in_side     = '0;
        dv_in_side.ctx = cr_out.ctx;
        dv_in_side.sx  = cr_out.dx[12];
        dv_in_side.sy  = cr_out.dy[12];
        dv_in_side.a   = clamp_angle(cr_ang[CORDIC_STEPS][0]);
        dv_in_side.b   = clamp_angle(cr_ang[CORDIC_STEPS][1]);
    end

    logic                       dv_valid [DV_N+1];
    logic [DV_SW-1:0]           dv_side  [DV_N+1];
    logic [2:0][DREM_W-1:0]     dv_rem   [DV_N+1];
    logic [2:0][QUO_W-1:0]      dv_bits  [DV_N+1];
    logic [2:0][QUO_W-1:0]      dv_quo   [DV_N+1];

    assign dv_valid[0] = cr_valid[CORDIC_STEPS];
    assign dv_side[0]  = dv_in_side;
    assign dv_quo[0]   = '0;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dv_rem[0][l]  = DREM_W'(mag[l] >> 1);
            dv_bits[0][l] = {mag[l][0], (QUO_W-1)'(0)};
        end
    end

    for (genvar g = 0; g < DV_N; g++) begin : g_div
        swsh_div_cell #(
            .LANES  (3),
            .SIDE_W (DV_SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .divisor   (radius_reg),
            .in_valid  (dv_valid[g]),
            .in_side   (dv_side[g]),
            .in_rem    (dv_rem[g]),
            .in_bits   (dv_bits[g]),
            .in_quo    (dv_quo[g]),
            .out_valid (dv_valid[g+1]),
            .out_side  (dv_side[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_bits  (dv_bits[g+1]),
            .out_quo   (dv_quo[g+1])
        );
    end

    // ---------------- P1: light products and texture coordinate products ----------------
    dv_side_t           dv_out;
    logic signed [15:0] nx, ny;
    logic signed [17:0] a18, b18;
    logic [7:0]         w_eff, h_eff;

    assign dv_out = dv_side[DV_N];
    assign nx  = dv_out.sx ? -$signed({1'b0, dv_quo[DV_N][0]}) : $signed({1'b0, dv_quo[DV_N][0]});
    assign ny  = dv_out.sy ? -$signed({1'b0, dv_quo[DV_N][1]}) : $signed({1'b0, dv_quo[DV_N][1]});
    assign a18 = 18'($signed(dv_out.a));
    assign b18 = 18'($signed(dv_out.b));

    // Saturate the frame size to 1..MAX
    assign w_eff = (frame_width_reg == 8'd0) ? 8'd1 :
                   ((frame_width_reg > MAX_WIDTH) ? 8'(MAX_WIDTH) : frame_width_reg);
    assign h_eff = (frame_height_reg == 8'd0) ? 8'd1 :
                   ((frame_height_reg > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : frame_height_reg);

    logic               p1_valid_reg;
    ctx_t               p1_ctx_reg;
    logic signed [31:0] pnx_reg, pny_reg;
    logic [29:0]        pnz_reg;
    logic [24:0]        col_num_reg, row_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= dv_valid[DV_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_ctx_reg  <= dv_out.ctx;
            pnx_reg     <= nx * light_x_reg;
            pny_reg     <= ny * light_y_reg;
            pnz_reg     <= dv_quo[DV_N][2] * light_z_reg;
            col_num_reg <= w_eff * 17'(a18 + 18'sd65536);
            row_num_reg <= h_eff * 17'(18'sd32768 - b18);
        end
    end

    // ---------------- P2: shade, source address, frame access ----------------
    logic signed [33:0] lsum;
    logic signed [19:0] lsum_sh;
    logic [14:0]        shade;
    logic [7:0]         col_raw, col_c;
    logic [8:0]         row_raw;
    logic [7:0]         row_c;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               wr_en;

    assign lsum    = 34'(pnx_reg) + 34'(pny_reg) + $signed({4'b0000, pnz_reg});
    assign lsum_sh = 20'(lsum >>> 14);
    assign shade   = (lsum <= 34'sd0) ? 15'd0 :
                     ((lsum_sh > 20'sd32767) ? 15'd32767 : 15'(lsum_sh));

    assign col_raw = 8'(col_num_reg >> 17);
    assign col_c   = (col_raw > w_eff - 8'd1) ? (w_eff - 8'd1) : col_raw;
    assign row_raw = 9'(row_num_reg >> 16);
    assign row_c   = (row_raw > {1'b0, h_eff - 8'd1}) ? (h_eff - 8'd1) : 8'(row_raw);

    assign rd_addr = ADDR_W'(row_c * MAX_WIDTH + col_c);
    assign wr_addr = ADDR_W'(p1_ctx_reg.pos_y * MAX_WIDTH + p1_ctx_reg.pos_x);
    // Drop stores outside the frame store
    assign wr_en   = p1_valid_reg && (p1_ctx_reg.func == FUNC_STORE) &&
                     (p1_ctx_reg.pos_x < MAX_WIDTH) && (p1_ctx_reg.pos_y < MAX_HEIGHT);

    logic [23:0] frame_mem [DEPTH];
    logic [23:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                frame_mem[wr_addr] <= p1_ctx_reg.rgb;
            end
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    logic        p2_valid_reg;
    logic        p2_inside_reg;
    logic [14:0] p2_shade_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg && (p1_ctx_reg.func == FUNC_RENDER);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_inside_reg <= p1_ctx_reg.in_sphere;
            p2_shade_reg  <= shade;
        end
    end

    // ---------------- P3: shaded colour into the output register ----------------
    logic [2:0][7:0] chan;

    always_comb begin
        logic [22:0] prod;
        logic [8:0]  scaled;
        for (int k = 0; k < 3; k++) begin
            prod    = rd_data_reg[8*k +: 8] * p2_shade_reg;
            scaled  = 9'(prod >> 14);
            chan[k] = (scaled > 9'd255) ? 8'd255 : 8'(scaled);
        end
    end

    logic [31:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (p2_inside_reg) begin
                m_data_reg <= {8'hFF, chan[2], chan[1], chan[0]};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/swsh_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring square-root step per lane: take two radicand bits, decide one root bit.
module swsh_sqrt_cell
    import swsh_pkg::*;
#(
    parameter int LANES  = 2,
    parameter int SIDE_W = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [SIDE_W-1:0]             in_side,
    input  wire logic [LANES-1:0][RAD_W-1:0]   in_rad,
    input  wire logic [LANES-1:0][SREM_W-1:0]  in_rem,
    input  wire logic [LANES-1:0][ROOT_W-1:0]  in_root,
    output logic                               out_valid,
    output logic [SIDE_W-1:0]                  out_side,
    output logic [LANES-1:0][RAD_W-1:0]        out_rad,
    output logic [LANES-1:0][SREM_W-1:0]       out_rem,
    output logic [LANES-1:0][ROOT_W-1:0]       out_root
);

    localparam int CUR_W = SREM_W + 2;

    logic                          valid_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic [LANES-1:0][RAD_W-1:0]   rad_reg, rad_next;
    logic [LANES-1:0][SREM_W-1:0]  rem_reg, rem_next;
    logic [LANES-1:0][ROOT_W-1:0]  root_reg, root_next;
    logic [LANES-1:0][CUR_W-1:0]   cur;
    logic [LANES-1:0][CUR_W-1:0]   trial;
    logic [LANES-1:0]              ge;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            cur[l]       = {in_rem[l], in_rad[l][RAD_W-1 -: 2]};
            trial[l]     = CUR_W'({in_root[l], 2'b01});
            ge[l]        = (cur[l] >= trial[l]);
            rem_next[l]  = ge[l] ? SREM_W'(cur[l] - trial[l]) : SREM_W'(cur[l]);
            root_next[l] = {in_root[l][ROOT_W-2:0], ge[l]};
            rad_next[l]  = {in_rad[l][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule
`default_nettype wire

// ===== rtl/swsh_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC vectoring step per lane: rotate towards y = 0, accumulate the angle.
module swsh_cordic_cell
    import swsh_pkg::*;
#(
    parameter int LANES  = 2,
    parameter int SIDE_W = 8,
    parameter int STEP   = 0
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [SIDE_W-1:0]            in_side,
    input  wire logic [LANES-1:0][CRD_W-1:0]  in_x,
    input  wire logic [LANES-1:0][CRD_W-1:0]  in_y,
    input  wire logic [LANES-1:0][ANG_W-1:0]  in_ang,
    output logic                              out_valid,
    output logic [SIDE_W-1:0]                 out_side,
    output logic [LANES-1:0][CRD_W-1:0]       out_x,
    output logic [LANES-1:0][CRD_W-1:0]       out_y,
    output logic [LANES-1:0][ANG_W-1:0]       out_ang
);

    localparam logic [ANG_W-1:0] ATAN = ANG_W'(ATAN_TABLE[STEP]);

    logic                          valid_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic [LANES-1:0][CRD_W-1:0]   x_reg, x_next;
    logic [LANES-1:0][CRD_W-1:0]   y_reg, y_next;
    logic [LANES-1:0][ANG_W-1:0]   ang_reg, ang_next;
    logic [LANES-1:0][CRD_W-1:0]   xs;
    logic [LANES-1:0][CRD_W-1:0]   ys;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            xs[l] = CRD_W'($signed(in_x[l]) >>> STEP);
            ys[l] = CRD_W'($signed(in_y[l]) >>> STEP);
            if (!in_y[l][CRD_W-1]) begin
                x_next[l]   = in_x[l] + ys[l];
                y_next[l]   = in_y[l] - xs[l];
                ang_next[l] = in_ang[l] + ATAN;
            end else begin
                x_next[l]   = in_x[l] - ys[l];
                y_next[l]   = in_y[l] + xs[l];
                ang_next[l] = in_ang[l] - ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;

endmodule
`default_nettype wire

// ===== rtl/swsh_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One restoring division step per lane: shift in one dividend bit, decide one quotient bit.
module swsh_div_cell
    import swsh_pkg::*;
#(
    parameter int LANES  = 3,
    parameter int SIDE_W = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic [MAG_W-1:0]              divisor,
    input  wire logic                          in_valid,
    input  wire logic [SIDE_W-1:0]             in_side,
    input  wire logic [LANES-1:0][DREM_W-1:0]  in_rem,
    input  wire logic [LANES-1:0][QUO_W-1:0]   in_bits,
    input  wire logic [LANES-1:0][QUO_W-1:0]   in_quo,
    output logic                               out_valid,
    output logic [SIDE_W-1:0]                  out_side,
    output logic [LANES-1:0][DREM_W-1:0]       out_rem,
    output logic [LANES-1:0][QUO_W-1:0]        out_bits,
    output logic [LANES-1:0][QUO_W-1:0]        out_quo
);

    localparam int CUR_W = DREM_W + 1;

    logic                          valid_reg;
    logic [SIDE_W-1:0]             side_reg;
    logic [LANES-1:0][DREM_W-1:0]  rem_reg, rem_next;
    logic [LANES-1:0][QUO_W-1:0]   bits_reg, bits_next;
    logic [LANES-1:0][QUO_W-1:0]   quo_reg, quo_next;
    logic [LANES-1:0][CUR_W-1:0]   cur;
    logic [CUR_W-1:0]              dvs;
    logic [LANES-1:0]              ge;

    always_comb begin
        dvs = CUR_W'(divisor);
        for (int l = 0; l < LANES; l++) begin
            cur[l]       = {in_rem[l], in_bits[l][QUO_W-1]};
            ge[l]        = (cur[l] >= dvs);
            rem_next[l]  = ge[l] ? DREM_W'(cur[l] - dvs) : DREM_W'(cur[l]);
            quo_next[l]  = {in_quo[l][QUO_W-2:0], ge[l]};
            bits_next[l] = {in_bits[l][QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
            quo_reg  <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_bits  = bits_reg;
    assign out_quo   = quo_reg;

endmodule
`default_nettype wire
